// File: design/clist_pkg.sv
// ----------------------------------------------------------------------------
// clist_pkg
// Shared sizes, codes and payload types of the circular list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package clist_pkg;

    // storage sizing
    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths of the request and response
    localparam int ACTION_W = 3;
    localparam int FIELD_W  = 32;
    localparam int STEP_W   = 8;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 7;

    // stored value width: the low VALUE_BITS of the value field
    localparam int STORE_W = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;

    // free slot finder: groups of eight slots, one registered flag per group
    localparam int GRP_SIZE  = 8;
    localparam int GRP_W     = 3;
    localparam int NUM_GRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NUM_GRP_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int PAD_W     = NUM_GRP * GRP_SIZE;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_BEFORE = 3'd0,
        ACT_INS_AFTER  = 3'd1,
        ACT_REMOVE     = 3'd2,
        ACT_ADVANCE    = 3'd3,
        ACT_SEARCH     = 3'd4,
        ACT_CLEAR      = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_PARAM = 3'd1,
        ST_POOL_FULL = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_PICK,
        S_INS_LINK1,
        S_INS_LINK2,
        S_RM_LINK,
        S_ADVANCE,
        S_SEARCH,
        S_SETTLE,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [FIELD_W-1:0]       value;
        logic signed [STEP_W-1:0] steps;
    } clist_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  current_value;
        logic [ENTRY_W-1:0]  entry_count;
    } clist_rsp_t;

    // lowest free slot as seen by the finder
    typedef struct packed {
        logic             full;
        logic [IDX_W-1:0] slot;
    } free_slot_t;

endpackage

`default_nettype wire

// File: design/clist_ram.sv
// ----------------------------------------------------------------------------
// clist_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module clist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/clist_free_find.sv
// ----------------------------------------------------------------------------
// clist_free_find
// Lowest free slot of the pool, through a registered two level tree.
// ----------------------------------------------------------------------------
`default_nettype none

module clist_free_find
    import clist_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic [CAPACITY-1:0] used,
    output free_slot_t               pick
);

    logic [PAD_W-1:0] used_pad;
    logic [NUM_GRP-1:0] grp_free_next;
    logic [NUM_GRP-1:0] grp_free_reg;
    logic [GRP_W-1:0] grp_off_next [NUM_GRP];
    logic [GRP_W-1:0] grp_off_reg  [NUM_GRP];
    logic [NUM_GRP_W-1:0] grp_sel;

    // slots past the capacity count as taken
    always_comb begin
        used_pad = '1;
        used_pad[CAPACITY-1:0] = used;
    end

    // first level: per group, any free and lowest free offset
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            grp_free_next[g] = ~&used_pad[g*GRP_SIZE +: GRP_SIZE];
            grp_off_next[g]  = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (!used_pad[g*GRP_SIZE + b]) begin
                    grp_off_next[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_free_reg <= grp_free_next;
        grp_off_reg  <= grp_off_next;
    end

    // second level: lowest group with a free slot
    always_comb begin
        pick.full = 1'b1;
        grp_sel   = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--) begin
            if (grp_free_reg[g]) begin
                pick.full = 1'b0;
                grp_sel   = NUM_GRP_W'(g);
            end
        end
        pick.slot = IDX_W'({grp_sel, grp_off_reg[grp_sel]});
    end

endmodule

`default_nettype wire

// File: design/circular_list_engine_core.sv
// ----------------------------------------------------------------------------
// circular_list_engine_core
// Circular doubly linked list over a fixed pool of slots, with a current
// entry, walked one link per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  s_      | in        | s_valid / s_ready  | s_req : action, value, steps
//  m_      | out       | m_valid / m_ready  | m_rsp : status, current_value,
//          |           |                    |         entry_count
//
//  one request at a time; s_ready is high only while the sequencer is idle
//  every request passes through S_SETTLE and S_LOAD; advance walks |steps|
//  links and search compares entries until a match or a full lap;
//  the walk is one link ram read per cycle
//  the response sits in an output register, so the next request is taken
//  while a response waits; a request only stalls in its final load step
//  reset (synchronous, aresetn low) empties the list; slot contents and
//  links are not cleared and are only read for slots in use
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_engine_core
    import clist_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire clist_req_t s_req,

    output logic            m_valid,
    input  wire logic       m_ready,
    output clist_rsp_t      m_rsp
);

    // sequencer
    state_t state_reg, state_next;

    // list control state
    logic [CAPACITY-1:0] used_reg, used_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic                nonempty_reg, nonempty_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // per request working registers
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [STORE_W-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [IDX_W-1:0]    nb_reg, nb_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [STEP_W-1:0]   remain_reg, remain_next;
    logic                fwd_reg, fwd_next;
    status_t             status_reg, status_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    clist_rsp_t          rsp_reg, rsp_next;

    // ram ports
    logic                val_we;
    logic [IDX_W-1:0]    val_waddr;
    logic [STORE_W-1:0]  val_wdata, val_rdata;
    logic                nxt_we, prv_we;
    logic [IDX_W-1:0]    nxt_waddr, nxt_wdata, nxt_rdata;
    logic [IDX_W-1:0]    prv_waddr, prv_wdata, prv_rdata;

    // request decode
    logic                accept;
    logic [STORE_W-1:0]  in_value;
    logic                in_zero;
    logic [STEP_W-1:0]   steps_raw;
    logic [STEP_W-1:0]   step_mag;
    state_t              dec_state;
    status_t             dec_status;
    logic                after_sel;
    logic                load_ok;
    free_slot_t          pick;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign in_value  = s_req.value[STORE_W-1:0];
    assign in_zero   = (in_value == '0);
    assign steps_raw = s_req.steps;
    // magnitude of a two's complement count; -128 gives 128
    assign step_mag  = steps_raw[STEP_W-1] ? (~steps_raw + STEP_W'(1)) : steps_raw;
    assign after_sel = (action_reg == ACT_INS_AFTER);
    assign load_ok   = !m_valid_reg || m_ready;

    // lowest free slot, refreshed every cycle from the used map
    clist_free_find u_free_find (
        .aclk (aclk),
        .used (used_reg),
        .pick (pick)
    );

    // all three rams read at the next current index, so that each cycle
    // their read data belongs to cur_reg; this is what lets a walk take
    // one link per cycle
    clist_ram #(.WIDTH(STORE_W), .DEPTH(CAPACITY)) u_val_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (val_wdata),
        .rd_addr (cur_next),
        .rd_data (val_rdata)
    );

    clist_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (nxt_we),
        .wr_addr (nxt_waddr),
        .wr_data (nxt_wdata),
        .rd_addr (cur_next),
        .rd_data (nxt_rdata)
    );

    clist_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prv_we),
        .wr_addr (prv_waddr),
        .wr_data (prv_wdata),
        .rd_addr (cur_next),
        .rd_data (prv_rdata)
    );

    // decode of an incoming request: first step and early status
    // zero value is checked before the empty list check
    always_comb begin
        dec_state  = S_SETTLE;
        dec_status = ST_OK;
        unique case (s_req.action)
            ACT_INS_BEFORE, ACT_INS_AFTER: begin
                if (in_zero) begin
                    dec_status = ST_BAD_PARAM;
                end else begin
                    dec_state = S_INS_PICK;
                end
            end
            ACT_REMOVE: begin
                if (!nonempty_reg) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_state = S_RM_LINK;
                end
            end
            ACT_ADVANCE: begin
                if (!nonempty_reg) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_state = S_ADVANCE;
                end
            end
            ACT_SEARCH: begin
                if (in_zero) begin
                    dec_status = ST_BAD_PARAM;
                end else if (!nonempty_reg) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_state = S_SEARCH;
                end
            end
            ACT_CLEAR: begin
                dec_status = ST_OK;
            end
            default: begin
                // unused action codes
                dec_status = ST_BAD_PARAM;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = dec_state;
                end
            end
            S_INS_PICK: begin
                if (pick.full || !nonempty_reg) begin
                    state_next = S_SETTLE;
                end else begin
                    state_next = S_INS_LINK1;
                end
            end
            S_INS_LINK1: state_next = S_INS_LINK2;
            S_INS_LINK2: state_next = S_SETTLE;
            S_RM_LINK:   state_next = S_SETTLE;
            S_ADVANCE: begin
                if (remain_reg == '0) begin
                    state_next = S_SETTLE;
                end
            end
            S_SEARCH: begin
                if (val_rdata == value_reg || nxt_rdata == start_reg) begin
                    state_next = S_SETTLE;
                end
            end
            // the value ram reads the final current entry before the load step
            S_SETTLE: state_next = S_LOAD;
            S_LOAD: begin
                if (load_ok) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        used_next     = used_reg;
        cur_next      = cur_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        action_next   = action_reg;
        value_next    = value_reg;
        slot_next     = slot_reg;
        nb_next       = nb_reg;
        start_next    = start_reg;
        remain_next   = remain_reg;
        fwd_next      = fwd_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rsp_next      = rsp_reg;

        val_we    = 1'b0;
        val_waddr = slot_reg;
        val_wdata = value_reg;
        nxt_we    = 1'b0;
        nxt_waddr = slot_reg;
        nxt_wdata = slot_reg;
        prv_we    = 1'b0;
        prv_waddr = slot_reg;
        prv_wdata = slot_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    action_next = s_req.action;
                    value_next  = in_value;
                    status_next = dec_status;
                    start_next  = cur_reg;
                    remain_next = step_mag;
                    fwd_next    = !steps_raw[STEP_W-1];
                    if (s_req.action == ACT_CLEAR) begin
                        used_next     = '0;
                        cur_next      = '0;
                        nonempty_next = 1'b0;
                        count_next    = '0;
                    end
                end
            end
            S_INS_PICK: begin
                if (pick.full) begin
                    status_next = ST_POOL_FULL;
                end else begin
                    slot_next             = pick.slot;
                    used_next[pick.slot]  = 1'b1;
                    count_next            = count_reg + COUNT_W'(1);
                    val_we                = 1'b1;
                    val_waddr             = pick.slot;
                    // neighbor on the side where the new entry goes
                    nb_next = after_sel ? nxt_rdata : prv_rdata;
                    if (!nonempty_reg) begin
                        // first entry links to itself
                        nxt_we        = 1'b1;
                        nxt_waddr     = pick.slot;
                        nxt_wdata     = pick.slot;
                        prv_we        = 1'b1;
                        prv_waddr     = pick.slot;
                        prv_wdata     = pick.slot;
                        cur_next      = pick.slot;
                        nonempty_next = 1'b1;
                    end
                end
            end
            S_INS_LINK1: begin
                // links of the new entry
                nxt_we    = 1'b1;
                nxt_waddr = slot_reg;
                nxt_wdata = after_sel ? nb_reg : cur_reg;
                prv_we    = 1'b1;
                prv_waddr = slot_reg;
                prv_wdata = after_sel ? cur_reg : nb_reg;
            end
            S_INS_LINK2: begin
                // splice the new entry between current and neighbor
                nxt_we    = 1'b1;
                nxt_waddr = after_sel ? cur_reg : nb_reg;
                nxt_wdata = slot_reg;
                prv_we    = 1'b1;
                prv_waddr = after_sel ? nb_reg : cur_reg;
                prv_wdata = slot_reg;
                cur_next  = slot_reg;
            end
            S_RM_LINK: begin
                used_next[cur_reg] = 1'b0;
                if (count_reg != '0) begin
                    count_next = count_reg - COUNT_W'(1);
                end
                if (prv_rdata == cur_reg) begin
                    // last entry gone
                    nonempty_next = 1'b0;
                    cur_next      = '0;
                end else begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rdata;
                    nxt_wdata = nxt_rdata;
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata;
                    prv_wdata = prv_rdata;
                    cur_next  = prv_rdata;
                end
            end
            S_ADVANCE: begin
                if (remain_reg != '0) begin
                    cur_next    = fwd_reg ? nxt_rdata : prv_rdata;
                    remain_next = remain_reg - STEP_W'(1);
                end
            end
            S_SEARCH: begin
                if (val_rdata == value_reg) begin
                    status_next = ST_OK;
                end else if (nxt_rdata == start_reg) begin
                    // full lap without a match: back to where the scan began
                    status_next = ST_NOT_FOUND;
                    cur_next    = start_reg;
                end else begin
                    cur_next = nxt_rdata;
                end
            end
            S_SETTLE: begin
            end
            S_LOAD: begin
                if (load_ok) begin
                    m_valid_next           = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.current_value = nonempty_reg ? FIELD_W'(val_rdata) : '0;
                    rsp_next.entry_count   = ENTRY_W'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            cur_reg      <= '0;
            nonempty_reg <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            cur_reg      <= cur_next;
            nonempty_reg <= nonempty_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        value_reg  <= value_next;
        slot_reg   <= slot_next;
        nb_reg     <= nb_next;
        start_reg  <= start_next;
        remain_reg <= remain_next;
        fwd_reg    <= fwd_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    // count never exceeds the pool
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // used map and entry count move together
    a_used_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) == int'(count_reg))
        else $error("used map out of step with entry count");

    // nonempty flag agrees with the count
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        nonempty_reg == (count_reg != '0))
        else $error("nonempty flag out of step with entry count");

    // an empty list answers with a zero current value
    a_empty_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.entry_count == '0) |-> (m_rsp.current_value == '0))
        else $error("nonzero current value on an empty list");

endmodule

`default_nettype wire
